[src/tpfc_pkg.sv]
// ----------------------------------------------------------------------------
// tpfc_pkg: shared types and constants of the teleoperation force controller
// Payload structs, command and register codes, sequencer states and the
// saturation helper used by the engine and its arithmetic unit.
// ----------------------------------------------------------------------------
package tpfc_pkg;

  localparam int AXES   = 3;
  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int ACC_W  = 58;
  localparam int ADDR_W = 4;

  localparam logic [23:0] PROP_GAIN_RST    = 24'd6554;
  localparam logic [23:0] DERIV_GAIN_RST   = 24'd655;
  localparam logic [16:0] SCALE_FACTOR_RST = 17'd32768;

  typedef struct packed {
    logic [2:0]          command;
    logic signed [31:0]  axis_x;
    logic signed [31:0]  axis_y;
    logic signed [31:0]  axis_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  force_x;
    logic signed [31:0]  force_y;
    logic signed [31:0]  force_z;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_MEAS_VEL     = 3'd0,
    CMD_PEER_VEL     = 3'd1,
    CMD_M1_VEL       = 3'd2,
    CMD_M2_VEL       = 3'd3,
    CMD_MASTER_FORCE = 3'd4,
    CMD_SLAVE_FORCE  = 3'd5,
    CMD_TICK         = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ROLE_NONE  = 2'd0,
    ROLE_M1    = 2'd1,
    ROLE_M2    = 2'd2,
    ROLE_SLAVE = 2'd3
  } role_t;

  typedef enum logic [1:0] {
    REG_PROP_GAIN    = 2'd0,
    REG_DERIV_GAIN   = 2'd1,
    REG_SCALE_FACTOR = 2'd2,
    REG_ROLE         = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] deriv_gain;
    logic [16:0] scale_factor;
    role_t       role;
  } cfg_t;

  typedef enum logic [2:0] {
    MAC_ADD,
    MAC_SUB,
    MAC_NEG,
    MAC_MUL,
    MAC_MLOAD,
    MAC_MSUB
  } mac_op_t;

  typedef struct packed {
    logic               valid;
    mac_op_t            op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [23:0]        coef;
  } mac_req_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
  } mac_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SCALE_WAIT,
    ST_ADD,
    ST_ADD_WAIT,
    ST_ERR,
    ST_ERR_WAIT,
    ST_KP,
    ST_KD,
    ST_PD_WAIT,
    ST_NEG,
    ST_NEG_WAIT,
    ST_TICK,
    ST_TICK_WAIT,
    ST_NEXT,
    ST_OUT
  } seq_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[ACC_W-1:31]) || (~|v[ACC_W-1:31])) begin
      r = v[31:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] in_component(input in_item_t d, input int idx);
    logic signed [31:0] r;
    if (idx == 1) begin
      r = d.axis_y;
    end else if (idx == 2) begin
      r = d.axis_z;
    end else begin
      r = d.axis_x;
    end
    return r;
  endfunction

endpackage

[src/tpfc_cfg.sv]
// ----------------------------------------------------------------------------
// tpfc_cfg: configuration register file
// APB-style port holding the gains, the scale factor and the device role.
// ----------------------------------------------------------------------------
module tpfc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpfc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tpfc_pkg::cfg_t              cfg
);

  logic                wr_en;
  tpfc_pkg::reg_idx_t  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = tpfc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain    <= tpfc_pkg::PROP_GAIN_RST;
      cfg.deriv_gain   <= tpfc_pkg::DERIV_GAIN_RST;
      cfg.scale_factor <= tpfc_pkg::SCALE_FACTOR_RST;
      cfg.role         <= tpfc_pkg::ROLE_NONE;
    end else if (wr_en) begin
      unique case (idx)
        tpfc_pkg::REG_PROP_GAIN:    cfg.prop_gain    <= pwdata[23:0];
        tpfc_pkg::REG_DERIV_GAIN:   cfg.deriv_gain   <= pwdata[23:0];
        tpfc_pkg::REG_SCALE_FACTOR: cfg.scale_factor <= pwdata[16:0];
        tpfc_pkg::REG_ROLE:         cfg.role         <= tpfc_pkg::role_t'(pwdata[1:0]);
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tpfc_pkg::REG_PROP_GAIN:    prdata = {8'd0, cfg.prop_gain};
      tpfc_pkg::REG_DERIV_GAIN:   prdata = {8'd0, cfg.deriv_gain};
      tpfc_pkg::REG_SCALE_FACTOR: prdata = {15'd0, cfg.scale_factor};
      tpfc_pkg::REG_ROLE:         prdata = {30'd0, cfg.role};
    endcase
  end

endmodule

[src/tpfc_mac.sv]
// ----------------------------------------------------------------------------
// tpfc_mac: shared arithmetic unit
// Two-stage multiply-accumulate with add, subtract and negate paths, Q16.16
// rescale on products and 32-bit saturation of the accumulator.
// ----------------------------------------------------------------------------
module tpfc_mac (
  input  logic               clk,
  input  logic               rst,
  input  tpfc_pkg::mac_req_t req,
  output tpfc_pkg::mac_rsp_t rsp
);

  localparam int AW = tpfc_pkg::ACC_W;

  logic signed [56:0]    prod;
  logic signed [AW-1:0]  a_ext;
  logic signed [AW-1:0]  b_ext;
  logic signed [AW-1:0]  term_next;
  logic signed [AW-1:0]  term;
  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  acc_adj;
  tpfc_pkg::mac_op_t     op1;
  tpfc_pkg::mac_op_t     op2;
  logic                  vld1;
  logic                  vld2;

  assign prod  = 57'(req.a) * 57'($signed({1'b0, req.coef}));
  assign a_ext = {{(AW-32){req.a[31]}}, req.a};
  assign b_ext = {{(AW-32){req.b[31]}}, req.b};

  always_comb begin
    unique case (req.op)
      tpfc_pkg::MAC_ADD: term_next = a_ext + b_ext;
      tpfc_pkg::MAC_SUB: term_next = a_ext - b_ext;
      tpfc_pkg::MAC_NEG: term_next = -a_ext;
      default:           term_next = {{(AW-57){prod[56]}}, prod};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      vld1 <= req.valid;
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    term <= term_next;
    op1  <= req.op;
    op2  <= op1;
    if (op1 == tpfc_pkg::MAC_MSUB) begin
      acc <= acc - term;
    end else begin
      acc <= term;
    end
  end

  assign acc_adj = ((op2 == tpfc_pkg::MAC_MUL) || (op2 == tpfc_pkg::MAC_MSUB)) ?
                   (acc >>> 16) : acc;

  assign rsp.valid = vld2 && (op2 != tpfc_pkg::MAC_MLOAD);
  assign rsp.value = tpfc_pkg::sat32(acc_adj);

endmodule

[src/tpfc_engine.sv]
// ----------------------------------------------------------------------------
// tpfc_engine: event sequencer and controller state
// Walks the axes one at a time, issuing each event's operations to the
// shared arithmetic unit and writing the results back to the state arrays.
// ----------------------------------------------------------------------------
module tpfc_engine (
  input  logic                clk,
  input  logic                rst,
  input  tpfc_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  tpfc_pkg::in_item_t  in_data,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tpfc_pkg::out_item_t out_data
);

  localparam int AXES = tpfc_pkg::AXES;
  localparam int AW   = tpfc_pkg::AXIS_W;
  localparam logic [AW-1:0] AXIS_LAST = AW'(AXES - 1);

  tpfc_pkg::seq_state_t state;
  tpfc_pkg::seq_state_t state_next;
  tpfc_pkg::mac_req_t   req;
  tpfc_pkg::mac_rsp_t   rsp;

  logic [2:0]         cmd;
  logic [AW-1:0]      axis;
  logic signed [31:0] vec        [AXES];
  logic signed [31:0] act_pos    [AXES];
  logic signed [31:0] meas_vel   [AXES];
  logic signed [31:0] des_pos    [AXES];
  logic signed [31:0] ctrl_force [AXES];
  logic signed [31:0] mstr_fb    [AXES];
  logic signed [31:0] slv_fb     [AXES];
  logic signed [31:0] held_out   [AXES];
  logic signed [31:0] scaled_vel;
  logic signed [31:0] err;
  logic signed [31:0] outs       [3];

  function automatic tpfc_pkg::seq_state_t first_state(input logic [2:0] c,
                                                       input tpfc_pkg::role_t r);
    tpfc_pkg::seq_state_t s;
    unique case (c)
      tpfc_pkg::CMD_MEAS_VEL,
      tpfc_pkg::CMD_PEER_VEL:     s = tpfc_pkg::ST_ADD;
      tpfc_pkg::CMD_M1_VEL,
      tpfc_pkg::CMD_M2_VEL:       s = tpfc_pkg::ST_SCALE;
      tpfc_pkg::CMD_MASTER_FORCE,
      tpfc_pkg::CMD_SLAVE_FORCE:  s = tpfc_pkg::ST_NEG;
      tpfc_pkg::CMD_TICK:         s = (r == tpfc_pkg::ROLE_NONE) ? tpfc_pkg::ST_OUT :
                                                                   tpfc_pkg::ST_TICK;
      default:                    s = tpfc_pkg::ST_IDLE;
    endcase
    return s;
  endfunction

  tpfc_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tpfc_pkg::ST_IDLE:       if (in_valid) begin
                                 state_next = first_state(in_data.command, cfg.role);
                               end
      tpfc_pkg::ST_SCALE:      state_next = tpfc_pkg::ST_SCALE_WAIT;
      tpfc_pkg::ST_SCALE_WAIT: if (rsp.valid) begin
                                 state_next = tpfc_pkg::ST_ADD;
                               end
      tpfc_pkg::ST_ADD:        state_next = tpfc_pkg::ST_ADD_WAIT;
      tpfc_pkg::ST_ADD_WAIT:   if (rsp.valid) begin
                                 state_next = (cmd == tpfc_pkg::CMD_MEAS_VEL) ?
                                              tpfc_pkg::ST_NEXT : tpfc_pkg::ST_ERR;
                               end
      tpfc_pkg::ST_ERR:        state_next = tpfc_pkg::ST_ERR_WAIT;
      tpfc_pkg::ST_ERR_WAIT:   if (rsp.valid) begin
                                 state_next = tpfc_pkg::ST_KP;
                               end
      tpfc_pkg::ST_KP:         state_next = tpfc_pkg::ST_KD;
      tpfc_pkg::ST_KD:         state_next = tpfc_pkg::ST_PD_WAIT;
      tpfc_pkg::ST_PD_WAIT:    if (rsp.valid) begin
                                 state_next = tpfc_pkg::ST_NEXT;
                               end
      tpfc_pkg::ST_NEG:        state_next = tpfc_pkg::ST_NEG_WAIT;
      tpfc_pkg::ST_NEG_WAIT:   if (rsp.valid) begin
                                 state_next = tpfc_pkg::ST_NEXT;
                               end
      tpfc_pkg::ST_TICK:       state_next = tpfc_pkg::ST_TICK_WAIT;
      tpfc_pkg::ST_TICK_WAIT:  if (rsp.valid) begin
                                 state_next = tpfc_pkg::ST_NEXT;
                               end
      tpfc_pkg::ST_NEXT:       if (axis == AXIS_LAST) begin
                                 state_next = (cmd == tpfc_pkg::CMD_TICK) ?
                                              tpfc_pkg::ST_OUT : tpfc_pkg::ST_IDLE;
                               end else begin
                                 state_next = first_state(cmd, cfg.role);
                               end
      tpfc_pkg::ST_OUT:        if (out_ready) begin
                                 state_next = tpfc_pkg::ST_IDLE;
                               end
    endcase
  end

  always_comb begin
    in_ready  = (state == tpfc_pkg::ST_IDLE);
    out_valid = (state == tpfc_pkg::ST_OUT);
    req.valid = 1'b0;
    req.op    = tpfc_pkg::MAC_ADD;
    req.a     = vec[axis];
    req.b     = '0;
    req.coef  = '0;
    unique case (state)
      tpfc_pkg::ST_SCALE: begin
        req.valid = 1'b1;
        req.op    = tpfc_pkg::MAC_MUL;
        req.coef  = {7'd0, cfg.scale_factor};
      end
      tpfc_pkg::ST_ADD: begin
        req.valid = 1'b1;
        if (cmd == tpfc_pkg::CMD_MEAS_VEL) begin
          req.a = act_pos[axis];
          req.b = vec[axis];
        end else if (cmd == tpfc_pkg::CMD_PEER_VEL) begin
          req.a = des_pos[axis];
          req.b = vec[axis];
        end else begin
          req.a = des_pos[axis];
          req.b = scaled_vel;
        end
      end
      tpfc_pkg::ST_ERR: begin
        req.valid = 1'b1;
        req.op    = tpfc_pkg::MAC_SUB;
        req.a     = des_pos[axis];
        req.b     = act_pos[axis];
      end
      tpfc_pkg::ST_KP: begin
        req.valid = 1'b1;
        req.op    = tpfc_pkg::MAC_MLOAD;
        req.a     = err;
        req.coef  = cfg.prop_gain;
      end
      tpfc_pkg::ST_KD: begin
        req.valid = 1'b1;
        req.op    = tpfc_pkg::MAC_MSUB;
        req.a     = meas_vel[axis];
        req.coef  = cfg.deriv_gain;
      end
      tpfc_pkg::ST_NEG: begin
        req.valid = 1'b1;
        req.op    = tpfc_pkg::MAC_NEG;
      end
      tpfc_pkg::ST_TICK: begin
        req.valid = 1'b1;
        req.a     = (cfg.role == tpfc_pkg::ROLE_M1) ? mstr_fb[axis] : ctrl_force[axis];
        req.b     = (cfg.role == tpfc_pkg::ROLE_SLAVE) ? 32'sd0 : slv_fb[axis];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= '0;
      for (int i = 0; i < AXES; i++) begin
        act_pos[i]    <= '0;
        meas_vel[i]   <= '0;
        des_pos[i]    <= '0;
        ctrl_force[i] <= '0;
        mstr_fb[i]    <= '0;
        slv_fb[i]     <= '0;
        held_out[i]   <= '0;
      end
    end else begin
      unique case (state)
        tpfc_pkg::ST_IDLE: if (in_valid) begin
          axis <= '0;
        end
        tpfc_pkg::ST_ADD_WAIT: if (rsp.valid) begin
          if (cmd == tpfc_pkg::CMD_MEAS_VEL) begin
            act_pos[axis]  <= rsp.value;
            meas_vel[axis] <= vec[axis];
          end else begin
            des_pos[axis]  <= rsp.value;
          end
        end
        tpfc_pkg::ST_PD_WAIT: if (rsp.valid) begin
          ctrl_force[axis] <= rsp.value;
        end
        tpfc_pkg::ST_NEG_WAIT: if (rsp.valid) begin
          if (cmd == tpfc_pkg::CMD_MASTER_FORCE) begin
            mstr_fb[axis] <= rsp.value;
          end else begin
            slv_fb[axis]  <= rsp.value;
          end
        end
        tpfc_pkg::ST_TICK_WAIT: if (rsp.valid) begin
          held_out[axis] <= rsp.value;
        end
        tpfc_pkg::ST_NEXT: if (axis != AXIS_LAST) begin
          axis <= axis + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= in_data.command;
      for (int i = 0; i < AXES; i++) begin
        vec[i] <= tpfc_pkg::in_component(in_data, (i < 3) ? i : 0);
      end
    end
    if ((state == tpfc_pkg::ST_SCALE_WAIT) && rsp.valid) begin
      scaled_vel <= rsp.value;
    end
    if ((state == tpfc_pkg::ST_ERR_WAIT) && rsp.valid) begin
      err <= rsp.value;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      outs[i] = '0;
    end
    for (int i = 0; (i < AXES) && (i < 3); i++) begin
      outs[i] = held_out[i];
    end
  end

  assign out_data.force_x = outs[0];
  assign out_data.force_y = outs[1];
  assign out_data.force_z = outs[2];

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input and output both open");

  a_rsp_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (state == tpfc_pkg::ST_SCALE_WAIT) || (state == tpfc_pkg::ST_ADD_WAIT) ||
                  (state == tpfc_pkg::ST_ERR_WAIT) || (state == tpfc_pkg::ST_PD_WAIT) ||
                  (state == tpfc_pkg::ST_NEG_WAIT) || (state == tpfc_pkg::ST_TICK_WAIT))
    else $error("unit result outside a wait state");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    axis <= AXIS_LAST)
    else $error("axis counter out of range");

  a_out_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready)
    else $error("not idle after result beat");

endmodule

[src/teleop_pd_force_controller.sv]
// ----------------------------------------------------------------------------
// teleop_pd_force_controller: three-axis teleoperation PD force controller
//
//   channel  handshake                   payload
//   in       in_valid / in_ready         in_data  (command, axis_x/y/z)
//   out      out_valid / out_ready       out_data (force_x/y/z)
//   cfg      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An item walks the axes; per axis measured velocity adds, force negates and
// tick sums; peer velocity also forms the error and applies the PD gains;
// M1/M2 velocity scales first. A tick adds its beat; with no role, only that.
// Each step goes through the two-stage shared multiply-accumulate unit.
// Reset is synchronous: state clears to zero, registers take their defaults.
// in_ready is low from acceptance until the item is done and, for a tick, its beat taken.
// ----------------------------------------------------------------------------
module teleop_pd_force_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  tpfc_pkg::in_item_t          in_data,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tpfc_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpfc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  tpfc_pkg::cfg_t cfg;

  tpfc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpfc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
